/* design/assert_macros.svh */
// Assertion macros used by the escaper top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check prop on every rising edge of clk outside reset.
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
// Check that cond never holds outside reset.
`define ASSERT_NEVER(label, clk, rst, cond) \
  `ASSERT_CLK(label, clk, rst, !(cond))
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

/* design/xce_pkg.sv */
// Types, character constants and classification helpers for the XML escaper.
`timescale 1ns / 1ps
package xce_pkg;

  localparam int unsigned IdxW = 3;
  typedef logic [IdxW-1:0] run_idx_t;

  typedef enum logic [2:0] {
    CLS_PASS,
    CLS_LT,
    CLS_GT,
    CLS_AMP,
    CLS_QUOT,
    CLS_APOS,
    CLS_DEL,
    CLS_CTRL
  } esc_class_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } enc_out_t;

  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_QUOT  = 8'h22;
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CTRL_MAX = 8'h1F;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  localparam run_idx_t MAX_LAST_IDX = 3'd5;

  function automatic esc_class_t classify(input logic [7:0] b);
    esc_class_t cls;
    cls = CLS_PASS;
    if (b == CH_LT) cls = CLS_LT;
    else if (b == CH_GT) cls = CLS_GT;
    else if (b == CH_AMP) cls = CLS_AMP;
    else if (b == CH_QUOT) cls = CLS_QUOT;
    else if (b == CH_APOS) cls = CLS_APOS;
    else if (b == CH_DEL) cls = CLS_DEL;
    else if (b <= CTRL_MAX && b != CH_TAB && b != CH_LF && b != CH_CR) cls = CLS_CTRL;
    return cls;
  endfunction

  function automatic run_idx_t last_index(input esc_class_t cls);
    run_idx_t idx;
    unique case (cls)
      CLS_PASS:                    idx = 3'd0;
      CLS_LT, CLS_GT:              idx = 3'd3;
      CLS_AMP, CLS_CTRL:           idx = 3'd4;
      CLS_QUOT, CLS_APOS, CLS_DEL: idx = 3'd5;
      default:                     idx = 3'd0;
    endcase
    return idx;
  endfunction

endpackage

/* design/xce_encode.sv */
// Byte encoder: gives one byte of the escaped run for a held byte and position.
`timescale 1ns / 1ps
module xce_encode (
  input  logic [7:0]        text_byte,
  input  xce_pkg::run_idx_t idx,
  output xce_pkg::enc_out_t enc
);
  import xce_pkg::*;

  esc_class_t cls;
  logic [4:0] ctrl_val;
  logic [1:0] tens;
  logic [3:0] ones;
  logic [7:0] tens_ch;
  logic [7:0] ones_ch;

  assign cls      = classify(text_byte);
  assign ctrl_val = text_byte[4:0];

  // Two decimal digits for a control byte, 0..31.
  always_comb begin
    if (ctrl_val >= 5'd30) tens = 2'd3;
    else if (ctrl_val >= 5'd20) tens = 2'd2;
    else if (ctrl_val >= 5'd10) tens = 2'd1;
    else tens = 2'd0;
    case (tens)
      2'd3:    ones = 4'(ctrl_val - 5'd30);
      2'd2:    ones = 4'(ctrl_val - 5'd20);
      2'd1:    ones = 4'(ctrl_val - 5'd10);
      default: ones = 4'(ctrl_val);
    endcase
  end

  assign tens_ch = CH_ZERO + 8'(tens);
  assign ones_ch = CH_ZERO + 8'(ones);

  always_comb begin
    enc.last = (idx == last_index(cls));
    enc.ch   = CH_SEMI;
    unique case (cls)
      CLS_PASS: enc.ch = text_byte;
      CLS_LT: begin
        case (idx)
          3'd0:    enc.ch = CH_AMP;
          3'd1:    enc.ch = "l";
          3'd2:    enc.ch = "t";
          default: enc.ch = CH_SEMI;
        endcase
      end
      CLS_GT: begin
        case (idx)
          3'd0:    enc.ch = CH_AMP;
          3'd1:    enc.ch = "g";
          3'd2:    enc.ch = "t";
          default: enc.ch = CH_SEMI;
        endcase
      end
      CLS_AMP: begin
        case (idx)
          3'd0:    enc.ch = CH_AMP;
          3'd1:    enc.ch = "a";
          3'd2:    enc.ch = "m";
          3'd3:    enc.ch = "p";
          default: enc.ch = CH_SEMI;
        endcase
      end
      CLS_QUOT: begin
        case (idx)
          3'd0:    enc.ch = CH_AMP;
          3'd1:    enc.ch = "q";
          3'd2:    enc.ch = "u";
          3'd3:    enc.ch = "o";
          3'd4:    enc.ch = "t";
          default: enc.ch = CH_SEMI;
        endcase
      end
      CLS_APOS: begin
        case (idx)
          3'd0:    enc.ch = CH_AMP;
          3'd1:    enc.ch = "a";
          3'd2:    enc.ch = "p";
          3'd3:    enc.ch = "o";
          3'd4:    enc.ch = "s";
          default: enc.ch = CH_SEMI;
        endcase
      end
      CLS_DEL: begin
        case (idx)
          3'd0:    enc.ch = CH_AMP;
          3'd1:    enc.ch = CH_HASH;
          3'd2:    enc.ch = "1";
          3'd3:    enc.ch = "2";
          3'd4:    enc.ch = "7";
          default: enc.ch = CH_SEMI;
        endcase
      end
      CLS_CTRL: begin
        case (idx)
          3'd0:    enc.ch = CH_AMP;
          3'd1:    enc.ch = CH_HASH;
          3'd2:    enc.ch = tens_ch;
          3'd3:    enc.ch = ones_ch;
          default: enc.ch = CH_SEMI;
        endcase
      end
      default: enc.ch = text_byte;
    endcase
  end

endmodule

/* design/xml_character_escaper_top.sv */
// Top level of the XML character escaper: input hold register, encoder, result register.
//
//   channel  | handshake              | payload
//   ---------+------------------------+--------------------
//   input    | start & !busy          | in_byte
//   result   | strobe (one cycle)     | out_byte, run_last
//
// Cycles: an item produces a run of 1 to 6 result bytes, one per cycle; the
// run length (1, 4, 5 or 6) is set by the held byte's class in the encoder.
// A plain byte is a run of one result byte, so a new item can be accepted every cycle.
// Path: an accepted byte goes through the hold register, the encoder and then the
// result register before its first result byte is on the ports.
// Reset: rst (synchronous) empties the hold register and drops strobe.
// Stalls: busy is high while the held item still has bytes after this one;
// the receiver cannot stall, so each result is shown for exactly one cycle.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module xml_character_escaper_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [7:0] in_byte,
  output logic       busy,
  output logic [7:0] out_byte,
  output logic       run_last,
  output logic       strobe
);
  import xce_pkg::*;

  // Hold register: the item being expanded and its position in the run.
  logic       hold_valid;
  logic [7:0] hold_byte;
  run_idx_t   idx;
  run_idx_t   idx_next;
  enc_out_t   enc;
  logic       accept;

  xce_encode u_encode (
    .text_byte (hold_byte),
    .idx       (idx),
    .enc       (enc)
  );

  // Busy only while the held item has bytes left after the current one; on
  // the last byte of a run the next item can load in the same cycle.
  assign busy     = hold_valid && !enc.last;
  assign accept   = start && !busy;
  assign idx_next = idx + 3'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      idx        <= '0;
    end else if (accept) begin
      // Load a fresh item and restart the run.
      hold_valid <= 1'b1;
      idx        <= '0;
    end else if (hold_valid && enc.last) begin
      // Run done and nothing new: drop the held item.
      hold_valid <= 1'b0;
      idx        <= '0;
    end else if (hold_valid) begin
      // Advance to the next byte of the run.
      idx <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_byte <= in_byte;
    end
  end

  // Result register: strobe marks one output byte per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= hold_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_byte <= enc.ch;
    run_last <= enc.last;
  end

  // A held item always yields a result on the next cycle.
  `ASSERT_CLK(a_accept_yields, clk, rst, hold_valid |=> strobe)
  // A run not yet finished continues on the very next cycle.
  `ASSERT_CLK(a_run_continues, clk, rst, (strobe && !run_last) |=> strobe)
  // The run position never passes the longest escape.
  `ASSERT_NEVER(a_idx_range, clk, rst, hold_valid && (idx > MAX_LAST_IDX))
  // Busy never rises without a held item.
  `ASSERT_NEVER(a_busy_needs_item, clk, rst, busy && !hold_valid)
  // An accepted item starts its run at the first byte.
  `ASSERT_CLK(a_new_run_first, clk, rst, accept |=> (idx == 3'd0))

endmodule
